// ===== hw/rtl/xenc_pkg.sv =====
// Shared types and constants for the x86-64 instruction byte encoder.
// No dependencies; the front end, queue, back end and top level import this package.
package xenc_pkg;

	localparam int MAX_BYTES   = 10;
	localparam int IDX_W       = 4;
	localparam int OFFSET_BITS = 32;
	localparam int OUT_OFF_W   = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [MAX_BYTES-1:0][7:0] byte_vec_t;

	typedef struct packed {
		byte_vec_t        bytes;
		logic [IDX_W-1:0] last_idx;
		logic             bad;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic   empty;
		entry_t head;
	} q_rd_t;

endpackage

// ===== hw/rtl/xenc_req_if.sv =====
// Request channel: one instruction request per item.
// Depends on nothing beyond the language itself.
interface xenc_req_if;
	logic               valid;
	logic               ready;
	logic [5:0]         form;
	logic [3:0]         reg_a;
	logic [3:0]         reg_b;
	logic [3:0]         cond;
	logic signed [31:0] disp;
	logic [63:0]        imm;

	modport source (output valid, form, reg_a, reg_b, cond, disp, imm, input ready);
	modport sink (input valid, form, reg_a, reg_b, cond, disp, imm, output ready);
endinterface

// ===== hw/rtl/xenc_byte_if.sv =====
// Code byte channel: one emitted machine-code byte per item.
// Depends on nothing beyond the language itself.
interface xenc_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  code_byte;
	logic [31:0] byte_offset;
	logic        last;
	logic        bad_form;

	modport source (output valid, code_byte, byte_offset, last, bad_form, input ready);
	modport sink (input valid, code_byte, byte_offset, last, bad_form, output ready);
endinterface

// ===== hw/rtl/xenc_front.sv =====
// Front end: accepts instruction requests and expands each into its byte list.
// Depends on xenc_pkg and xenc_req_if; writes into the entry queue.
module xenc_front
	import xenc_pkg::*;
(
	xenc_req_if.sink req,
	input  logic     q_full,
	output q_wr_t    q_wr
);

	typedef enum logic [5:0] {
		F_MOV_RI64 = 6'd0, F_MOV_RM, F_MOV_MR, F_MOV_RR, F_ADD_RR, F_SUB_RR, F_AND_RR,
		F_OR_RR, F_XOR_RR, F_CMP_RR, F_TEST_RR, F_IMUL_RR, F_NEG, F_NOT, F_CQO, F_IDIV,
		F_SHL, F_SHR, F_SAR, F_ADD_RI, F_CMP_RI, F_SETCC, F_MOVZX, F_PUSH_RBP, F_POP_RBP,
		F_MOV_RBP_RSP, F_MOV_RSP_RBP, F_SUB_RSP, F_RET, F_UD2, F_JMP, F_JCC, F_CALL,
		F_MOVSD_LD, F_MOVSD_ST, F_ADDSD, F_SUBSD, F_MULSD, F_DIVSD, F_UCOMISD,
		F_CVTSI2SD, F_MOVQ_XG, F_MOVQ_GX
	} form_e;

	typedef struct packed {
		byte_vec_t        bytes;
		logic [IDX_W-1:0] cnt;
	} enc_t;

	function automatic enc_t put(enc_t e, logic [7:0] v);
		enc_t r;
		r = e;
		r.bytes[e.cnt] = v;
		r.cnt = e.cnt + IDX_W'(1);
		return r;
	endfunction

	function automatic enc_t put32(enc_t e, logic [31:0] v);
		enc_t r;
		r = e;
		for (int i = 0; i < 4; i++) begin
			r = put(r, v[8*i +: 8]);
		end
		return r;
	endfunction

	function automatic enc_t put64(enc_t e, logic [63:0] v);
		enc_t r;
		r = e;
		for (int i = 0; i < 8; i++) begin
			r = put(r, v[8*i +: 8]);
		end
		return r;
	endfunction

	function automatic logic [7:0] rex_w(logic [3:0] r, logic [3:0] m);
		return {4'h4, 1'b1, r[3], 1'b0, m[3]};
	endfunction

	function automatic logic [7:0] mod_reg(logic [3:0] r, logic [3:0] m);
		return {2'b11, r[2:0], m[2:0]};
	endfunction

	function automatic logic [7:0] mod_rbp(logic [3:0] r);
		return {2'b10, r[2:0], 3'b101};
	endfunction

	function automatic enc_t sse_rex(enc_t e, logic [3:0] r, logic [3:0] m, logic w);
		logic [7:0] x;
		x = {4'h4, w, r[3], 1'b0, m[3]};
		return (x != 8'h40) ? put(e, x) : e;
	endfunction

	function automatic enc_t alu_rr(enc_t e, logic [7:0] op, logic [3:0] dst, logic [3:0] src);
		return put(put(put(e, rex_w(src, dst)), op), mod_reg(src, dst));
	endfunction

	function automatic enc_t unary(enc_t e, logic [7:0] op, logic [2:0] ext, logic [3:0] r);
		return put(put(put(e, rex_w(4'd0, r)), op), mod_reg({1'b0, ext}, r));
	endfunction

	function automatic enc_t sse_op(enc_t e, logic [7:0] pfx, logic [7:0] op,
			logic [3:0] r, logic [3:0] m, logic w);
		enc_t t;
		t = sse_rex(put(e, pfx), r, m, w);
		return put(put(put(t, 8'h0f), op), mod_reg(r, m));
	endfunction

	function automatic enc_t sse_mem(enc_t e, logic [7:0] op, logic [3:0] r, logic [31:0] d);
		enc_t t;
		t = sse_rex(put(e, 8'hf2), r, 4'd5, 1'b0);
		return put32(put(put(put(t, 8'h0f), op), mod_rbp(r)), d);
	endfunction

	enc_t       e;
	logic       bad;
	logic [3:0] a;
	logic [3:0] b;
	logic [3:0] cc;
	logic [31:0] d;

	assign a  = req.reg_a;
	assign b  = req.reg_b;
	assign cc = req.cond;
	assign d  = req.disp;

	always_comb begin
		e   = '0;
		bad = 1'b0;
		case (form_e'(req.form))
			F_MOV_RI64: begin
				e = put(e, {4'h4, 3'b100, a[3]});
				e = put(e, {5'b10111, a[2:0]});
				e = put64(e, req.imm);
			end
			F_MOV_RM:      e = put32(put(put(put(e, rex_w(a, 4'd5)), 8'h8b), mod_rbp(a)), d);
			F_MOV_MR:      e = put32(put(put(put(e, rex_w(a, 4'd5)), 8'h89), mod_rbp(a)), d);
			F_MOV_RR:      e = alu_rr(e, 8'h89, a, b);
			F_ADD_RR:      e = alu_rr(e, 8'h01, a, b);
			F_SUB_RR:      e = alu_rr(e, 8'h29, a, b);
			F_AND_RR:      e = alu_rr(e, 8'h21, a, b);
			F_OR_RR:       e = alu_rr(e, 8'h09, a, b);
			F_XOR_RR:      e = alu_rr(e, 8'h31, a, b);
			F_CMP_RR:      e = alu_rr(e, 8'h39, a, b);
			F_TEST_RR:     e = alu_rr(e, 8'h85, a, b);
			F_IMUL_RR:     e = put(put(put(put(e, rex_w(a, b)), 8'h0f), 8'haf), mod_reg(a, b));
			F_NEG:         e = unary(e, 8'hf7, 3'd3, a);
			F_NOT:         e = unary(e, 8'hf7, 3'd2, a);
			F_CQO:         e = put(put(e, 8'h48), 8'h99);
			F_IDIV:        e = unary(e, 8'hf7, 3'd7, a);
			F_SHL:         e = unary(e, 8'hd3, 3'd4, a);
			F_SHR:         e = unary(e, 8'hd3, 3'd5, a);
			F_SAR:         e = unary(e, 8'hd3, 3'd7, a);
			F_ADD_RI:      e = put32(unary(e, 8'h81, 3'd0, a), d);
			F_CMP_RI:      e = put32(unary(e, 8'h81, 3'd7, a), d);
			F_SETCC: begin
				if (a >= 4'd4) begin
					e = put(e, {7'b0100000, a[3]});
				end
				e = put(put(put(e, 8'h0f), {4'h9, cc}), {5'b11000, a[2:0]});
			end
			F_MOVZX:       e = put(put(put(put(e, rex_w(a, a)), 8'h0f), 8'hb6), mod_reg(a, a));
			F_PUSH_RBP:    e = put(e, 8'h55);
			F_POP_RBP:     e = put(e, 8'h5d);
			F_MOV_RBP_RSP: e = put(put(put(e, 8'h48), 8'h89), 8'he5);
			F_MOV_RSP_RBP: e = put(put(put(e, 8'h48), 8'h89), 8'hec);
			F_SUB_RSP:     e = put32(put(put(put(e, 8'h48), 8'h81), 8'hec), d);
			F_RET:         e = put(e, 8'hc3);
			F_UD2:         e = put(put(e, 8'h0f), 8'h0b);
			F_JMP:         e = put32(put(e, 8'he9), d);
			F_JCC:         e = put32(put(put(e, 8'h0f), {4'h8, cc}), d);
			F_CALL:        e = put32(put(e, 8'he8), d);
			F_MOVSD_LD:    e = sse_mem(e, 8'h10, a, d);
			F_MOVSD_ST:    e = sse_mem(e, 8'h11, a, d);
			F_ADDSD:       e = sse_op(e, 8'hf2, 8'h58, a, b, 1'b0);
			F_SUBSD:       e = sse_op(e, 8'hf2, 8'h5c, a, b, 1'b0);
			F_MULSD:       e = sse_op(e, 8'hf2, 8'h59, a, b, 1'b0);
			F_DIVSD:       e = sse_op(e, 8'hf2, 8'h5e, a, b, 1'b0);
			F_UCOMISD:     e = sse_op(e, 8'h66, 8'h2e, a, b, 1'b0);
			F_CVTSI2SD:    e = sse_op(e, 8'hf2, 8'h2a, a, b, 1'b1);
			F_MOVQ_XG:     e = sse_op(e, 8'h66, 8'h6e, a, b, 1'b1);
			F_MOVQ_GX:     e = sse_op(e, 8'h66, 8'h7e, b, a, 1'b1);
			default: begin
				e.cnt = IDX_W'(1);
				bad   = 1'b1;
			end
		endcase
	end

	assign req.ready         = !q_full;
	assign q_wr.push         = req.valid && !q_full;
	assign q_wr.entry.bytes  = e.bytes;
	assign q_wr.entry.last_idx = e.cnt - IDX_W'(1);
	assign q_wr.entry.bad    = bad;

endmodule

// ===== hw/rtl/xenc_queue.sv =====
// Two-entry queue of expanded instructions between front and back end.
// Depends on xenc_pkg.
module xenc_queue
	import xenc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t q_wr,
	input  logic  pop,
	output logic  full,
	output q_rd_t q_rd
);

	entry_t     entries_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'(QUEUE_DEPTH));
	assign q_rd.empty = (cnt_q == 2'd0);
	assign q_rd.head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(q_wr.push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			entries_q[wr_ptr_q] <= q_wr.entry;
		end
	end

endmodule

// ===== hw/rtl/xenc_back.sv =====
// Back end: walks the queue head one byte per cycle while the output accepts, and keeps the code position.
// Depends on xenc_pkg and xenc_byte_if; reads from the entry queue.
module xenc_back
	import xenc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_rd_t     q_rd,
	output logic      pop,
	xenc_byte_if.source code
);

	logic [IDX_W-1:0]       idx_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   out_valid_q;
	logic [7:0]             byte_q;
	logic [OUT_OFF_W-1:0]   offset_q;
	logic                   last_q;
	logic                   bad_q;
	logic                   load;
	logic                   at_last;

	assign load    = !q_rd.empty && (!out_valid_q || code.ready);
	assign at_last = (idx_q == q_rd.head.last_idx);
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_last ? '0 : idx_q + IDX_W'(1);
			if (!q_rd.head.bad) begin
				pos_q <= pos_q + OFFSET_BITS'(1);
			end
		end else if (code.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= q_rd.head.bytes[idx_q];
			offset_q <= OUT_OFF_W'(pos_q);
			last_q   <= at_last;
			bad_q    <= q_rd.head.bad;
		end
	end

	assign code.valid       = out_valid_q;
	assign code.code_byte   = byte_q;
	assign code.byte_offset = offset_q;
	assign code.last        = last_q;
	assign code.bad_form    = bad_q;

endmodule

// ===== hw/rtl/x86_64_instruction_byte_encoder.sv =====
// Top level of the x86-64 instruction byte encoder: front end, queue and back end.
// Depends on xenc_pkg, xenc_req_if, xenc_byte_if, xenc_front, xenc_queue, xenc_back.
//
// Each accepted request is expanded in the cycle it is accepted into a list of one to
// ten machine-code bytes, which waits in a two-entry queue. The back end sends one byte
// per cycle from the queue head while the output port accepts them, so the byte output
// port sets the sustained rate. Requests are taken every cycle while the queue has
// room, also while a byte waits on the output. An undefined form gives a single zero
// byte with bad_form and last set, and leaves the code position unchanged.
module x86_64_instruction_byte_encoder
	import xenc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	xenc_req_if.sink    instr,
	xenc_byte_if.source code
);

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  pop;

	xenc_front u_front (
		.req    (instr),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	xenc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.full   (q_full),
		.q_rd   (q_rd)
	);

	xenc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.pop    (pop),
		.code   (code)
	);

	assert property (@(posedge clk) disable iff (!arst_n) q_wr.push |-> !q_full)
		else $error("Queue written while full.");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_rd.empty)
		else $error("Queue popped while empty.");

	assert property (@(posedge clk) disable iff (!arst_n)
		code.valid && code.bad_form |-> code.last && (code.code_byte == 8'h00))
		else $error("Undefined form did not give a single zero byte.");

	assert property (@(posedge clk) disable iff (!arst_n)
		code.valid && code.ready && !code.bad_form && !code.last
		|=> code.valid && (code.byte_offset == $past(code.byte_offset) + 32'd1))
		else $error("Bytes of one instruction are not contiguous.");

endmodule
